// File: design/mpeg_audio_header_decoder_assert.svh
// Assertion macros shared by the header decoder RTL.
`ifndef MPEG_AUDIO_HEADER_DECODER_ASSERT_SVH
`define MPEG_AUDIO_HEADER_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAHD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mahd same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MAHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mahd next-cycle check failed");

`endif

// File: design/mahd_pkg.sv
// Types, codes and lookup tables for the MPEG audio header decoder.
package mahd_pkg;

  localparam int unsigned QUO_W = 12;
  localparam int unsigned REM_W = 16;
  localparam int unsigned NUM_W = 27;

  localparam logic [1:0] VER_MPEG25 = 2'd0;
  localparam logic [1:0] VER_RSVD   = 2'd1;
  localparam logic [1:0] VER_MPEG2  = 2'd2;
  localparam logic [1:0] VER_MPEG1  = 2'd3;

  localparam logic [1:0] LAY_RSVD = 2'd0;
  localparam logic [1:0] LAY_L3   = 2'd1;
  localparam logic [1:0] LAY_L2   = 2'd2;
  localparam logic [1:0] LAY_L1   = 2'd3;

  localparam logic [1:0] SRI_RSVD    = 2'd3;
  localparam logic [1:0] MODE_SINGLE = 2'd3;
  localparam logic [3:0] BRI_FREE    = 4'd0;
  localparam logic [3:0] BRI_BAD     = 4'h0f;

  localparam logic [2:0] COL_V1_L1  = 3'd0;
  localparam logic [2:0] COL_V1_L2  = 3'd1;
  localparam logic [2:0] COL_V1_L3  = 3'd2;
  localparam logic [2:0] COL_V2_L1  = 3'd3;
  localparam logic [2:0] COL_V2_L23 = 3'd4;

  localparam logic [17:0] MULT_L1   = 18'd12000;
  localparam logic [17:0] MULT_FULL = 18'd144000;
  localparam logic [17:0] MULT_HALF = 18'd72000;

  localparam logic [10:0] SPF_L1   = 11'd384;
  localparam logic [10:0] SPF_FULL = 11'd1152;
  localparam logic [10:0] SPF_HALF = 11'd576;

  localparam logic [8:0] KBPS_TAB [16][5] = '{
    '{9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
    '{9'd32,  9'd32,  9'd32,  9'd32,  9'd8},
    '{9'd64,  9'd48,  9'd40,  9'd48,  9'd16},
    '{9'd96,  9'd56,  9'd48,  9'd56,  9'd24},
    '{9'd128, 9'd64,  9'd56,  9'd64,  9'd32},
    '{9'd160, 9'd80,  9'd64,  9'd80,  9'd40},
    '{9'd192, 9'd96,  9'd80,  9'd96,  9'd48},
    '{9'd224, 9'd112, 9'd96,  9'd112, 9'd56},
    '{9'd256, 9'd128, 9'd112, 9'd128, 9'd64},
    '{9'd288, 9'd160, 9'd128, 9'd144, 9'd80},
    '{9'd320, 9'd192, 9'd160, 9'd160, 9'd96},
    '{9'd352, 9'd224, 9'd192, 9'd176, 9'd112},
    '{9'd384, 9'd256, 9'd224, 9'd192, 9'd128},
    '{9'd416, 9'd320, 9'd256, 9'd224, 9'd144},
    '{9'd448, 9'd384, 9'd320, 9'd256, 9'd160},
    '{9'd0,   9'd0,   9'd0,   9'd0,   9'd0}
  };

  function automatic logic [15:0] base_rate(input logic [1:0] sri);
    logic [15:0] r;
    case (sri)
      2'd0:    r = 16'd44100;
      2'd1:    r = 16'd48000;
      2'd2:    r = 16'd32000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // One word travelling down the divider row.
  typedef struct packed {
    logic              ok;
    logic              pad;
    logic              lay1;
    logic [15:0]       rate;
    logic [8:0]        kbps;
    logic [10:0]       spf;
    logic [1:0]        chans;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  dvd;
    logic [QUO_W-1:0]  quo;
  } pipe_t;

endpackage

// File: design/mahd_front.sv
// Header field decode, table lookup and numerator multiply stage.
module mahd_front
  import mahd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] header_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pipe_t       out_o
);

  logic        valid_q;
  pipe_t       data_q, data_d;
  logic [1:0]  ver, lay, sri, mode;
  logic [3:0]  bri;
  logic        ok;
  logic [15:0] base;
  logic [2:0]  col;
  logic [17:0] mult;
  logic [8:0]  kbps;
  logic [NUM_W-1:0] num;

  assign ver  = header_i[20:19];
  assign lay  = header_i[18:17];
  assign bri  = header_i[15:12];
  assign sri  = header_i[11:10];
  assign mode = header_i[7:6];
  assign ok   = (&header_i[31:21]) && (ver != VER_RSVD) && (lay != LAY_RSVD) &&
                (sri != SRI_RSVD) && (bri != BRI_FREE) && (bri != BRI_BAD);
  assign base = base_rate(sri);

  always_comb begin
    if (lay == LAY_L1) begin
      col  = (ver == VER_MPEG1) ? COL_V1_L1 : COL_V2_L1;
      mult = MULT_L1;
    end else if (ver == VER_MPEG1) begin
      col  = (lay == LAY_L2) ? COL_V1_L2 : COL_V1_L3;
      mult = MULT_FULL;
    end else begin
      col  = COL_V2_L23;
      mult = (lay == LAY_L3) ? MULT_HALF : MULT_FULL;
    end
    kbps = KBPS_TAB[bri][col];
    num  = NUM_W'(mult) * NUM_W'(kbps);

    data_d       = '0;
    data_d.ok    = ok;
    data_d.pad   = header_i[9];
    data_d.lay1  = (lay == LAY_L1);
    data_d.kbps  = kbps;
    data_d.chans = (mode == MODE_SINGLE) ? 2'd1 : 2'd2;
    case (ver)
      VER_MPEG1: data_d.rate = base;
      VER_MPEG2: data_d.rate = base >> 1;
      default:   data_d.rate = base >> 2;
    endcase
    if (lay == LAY_L1) begin
      data_d.spf = SPF_L1;
    end else if (ver != VER_MPEG1 && lay == LAY_L3) begin
      data_d.spf = SPF_HALF;
    end else begin
      data_d.spf = SPF_FULL;
    end
    data_d.rem = REM_W'(num[NUM_W-1:QUO_W]);
    data_d.dvd = num[QUO_W-1:0];
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: design/mahd_div_cell.sv
// One restoring-division cell: yields one quotient bit per word.
module mahd_div_cell
  import mahd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  pipe_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output pipe_t out_o
);

  logic         valid_q;
  pipe_t        data_q, data_d;
  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic         ge;

  always_comb begin
    trial  = {in_i.rem, in_i.dvd[QUO_W-1]};
    ge     = trial >= {1'b0, in_i.rate};
    diff   = trial - {1'b0, in_i.rate};
    data_d = in_i;
    data_d.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    data_d.dvd = {in_i.dvd[QUO_W-2:0], 1'b0};
    data_d.quo = {in_i.quo[QUO_W-2:0], ge};
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// File: design/mahd_back.sv
// Output register: frame length finish and reject masking.
module mahd_back
  import mahd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pipe_t       in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [11:0] frame_bytes_o,
  output logic [15:0] rate_o,
  output logic [8:0]  kbps_o,
  output logic [10:0] spf_o,
  output logic [1:0]  chans_o
);

  logic        valid_q;
  logic        ok_q;
  logic [11:0] frame_q, frame_d, slots;
  logic [15:0] rate_q;
  logic [8:0]  kbps_q;
  logic [10:0] spf_q;
  logic [1:0]  chans_q;

  always_comb begin
    slots   = in_i.quo + 12'(in_i.pad);
    frame_d = in_i.lay1 ? {slots[9:0], 2'b00} : slots;
  end

  assign in_ready_o    = !valid_q || out_ready_i;
  assign out_valid_o   = valid_q;
  assign ok_o          = ok_q;
  assign frame_bytes_o = frame_q;
  assign rate_o        = rate_q;
  assign kbps_o        = kbps_q;
  assign spf_o         = spf_q;
  assign chans_o       = chans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ok_q    <= in_i.ok;
      frame_q <= in_i.ok ? frame_d    : '0;
      rate_q  <= in_i.ok ? in_i.rate  : '0;
      kbps_q  <= in_i.ok ? in_i.kbps  : '0;
      spf_q   <= in_i.ok ? in_i.spf   : '0;
      chans_q <= in_i.ok ? in_i.chans : '0;
    end
  end

endmodule

// File: design/mpeg_audio_header_decoder.sv
// MPEG audio frame header decoder: top level.
//
// Slave stream: one 32-bit header word per handshake, first header byte in bits 31..24.
// Master stream: one decoded word per header; tuser carries header_ok, tdata the
// frame length, sample rate, bitrate, samples per frame and channel count.
// A rejected header (bad sync, reserved codes, free or bad bitrate) gives a word
// with every field zero.
// Pipeline: 14 register stages: one decode/multiply stage, a row of 12 divider
// cells (one quotient bit each, dividing by the sample rate), and the output
// register. The accept edge loads the first stage; each word then passes the
// divider cells in order and leaves from the output register.
// Throughput: one header per cycle unless stalled; every stage carries its own valid.
// Stall: a low m_axis_tready freezes the row stage by stage; s_axis_tready drops
// only once every stage holds a word.
// Reset: all stage valids clear, no word is in flight; no warm-up is needed.
`include "mpeg_audio_header_decoder_assert.svh"

module mpeg_audio_header_decoder
  import mahd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] header_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [11:0] frame_bytes, [27:12] sample_rate_hz,
                                      // [36:28] bitrate_kbps, [47:37] samples_in_frame,
                                      // [49:48] channel_count, [55:50] zero
  output logic [0:0]  m_axis_tuser    // [0] header_ok
);

  pipe_t        row   [QUO_W+1];
  logic         row_v [QUO_W+1];
  logic         row_r [QUO_W+1];
  logic         ok;
  logic [11:0]  frame_bytes;
  logic [15:0]  sample_rate_hz;
  logic [8:0]   bitrate_kbps;
  logic [10:0]  samples_in_frame;
  logic [1:0]   channel_count;

  mahd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .header_i    (s_axis_tdata),
    .out_valid_o (row_v[0]),
    .out_ready_i (row_r[0]),
    .out_o       (row[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    mahd_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (row_v[i]),
      .in_ready_o  (row_r[i]),
      .in_i        (row[i]),
      .out_valid_o (row_v[i+1]),
      .out_ready_i (row_r[i+1]),
      .out_o       (row[i+1])
    );
  end

  mahd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (row_v[QUO_W]),
    .in_ready_o    (row_r[QUO_W]),
    .in_i          (row[QUO_W]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .ok_o          (ok),
    .frame_bytes_o (frame_bytes),
    .rate_o        (sample_rate_hz),
    .kbps_o        (bitrate_kbps),
    .spf_o         (samples_in_frame),
    .chans_o       (channel_count)
  );

  assign m_axis_tuser = ok;
  assign m_axis_tdata = {6'd0, channel_count, samples_in_frame, bitrate_kbps,
                         sample_rate_hz, frame_bytes};

  `MAHD_ASSERT_NOW(a_reject_zero, clk_i, rst_ni,
    m_axis_tvalid && !ok, (m_axis_tdata == '0))
  `MAHD_ASSERT_NOW(a_ok_fields, clk_i, rst_ni,
    m_axis_tvalid && ok,
    (frame_bytes != '0) && (sample_rate_hz != '0) && (bitrate_kbps != '0) &&
    (samples_in_frame != '0) && (channel_count != '0))
  `MAHD_ASSERT_NOW(a_full_when_blocked, clk_i, rst_ni,
    !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  `MAHD_ASSERT_NEXT(a_frozen_row, clk_i, rst_ni,
    !s_axis_tready && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule
